FILE: design/stbg_pkg.sv
// Shared constants, types and the quarter-wave sine table of the tone-burst generator.
package stbg_pkg;

  localparam int SampleRateHz = 16000;
  localparam int Amplitude    = 12000;
  localparam int TableBits    = 10;

  localparam int PhaseW  = 32;
  localparam int CountW  = 20;
  localparam int SampleW = 15;
  localparam int FreqW   = 16;
  localparam int MsW     = 16;

  localparam int QuarterBits = TableBits - 2;
  localparam int QuarterLen  = 1 << QuarterBits;

  localparam logic [CountW-1:0] CountMax = '1;

  // The phase step is frequency * 2^32 / rate, taken as a product with a rounded-up
  // reciprocal and a right shift. The shift is wide enough that the result is exact.
  localparam int StepShift = 32;
  localparam logic [95:0] StepMul =
      ((96'd1 << (PhaseW + StepShift)) + 96'(SampleRateHz - 1)) / 96'(SampleRateHz);
  localparam int StepMulW = PhaseW + StepShift + 1 - $clog2(SampleRateHz);
  localparam int StepLoW  = StepMulW / 2;
  localparam int StepHiW  = StepMulW - StepLoW;
  localparam logic [StepLoW-1:0] StepMulLo = StepMul[StepLoW-1:0];
  localparam logic [StepHiW-1:0] StepMulHi = StepMul[StepMulW-1:StepLoW];
  localparam int StepLoProdW = FreqW + StepLoW;
  localparam int StepHiProdW = FreqW + StepHiW;
  localparam int StepProdW   = FreqW + StepMulW;

  // The sample count is milliseconds * rate / 1000, again as an exact reciprocal product.
  localparam int CountShift = 26;
  localparam logic [63:0] CountMul = ((64'(SampleRateHz) << CountShift) + 64'd999) / 64'd1000;
  localparam int CountMulW  = $clog2(CountMul + 64'd1);
  localparam int CountProdW = MsW + CountMulW;
  localparam int CountRawW  = CountProdW - CountShift;

  localparam logic [63:0] PiHalfQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;
  localparam logic [63:0] MagLimit  = 64'd1 << (SampleW - 1);

  localparam logic [SampleW-1:0] MaxPos = SampleW'((1 << (SampleW - 1)) - 1);

  typedef enum logic {
    CmdStart = 1'b0,
    CmdTick  = 1'b1
  } cmd_e;

  typedef logic [SampleW-1:0] qtab_t [QuarterLen];

  // Scaled sine magnitude for one point of the first quadrant, clipped to the sample range.
  function automatic logic [SampleW-1:0] quarter_mag(int unsigned q);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] mag;
    x    = (64'(q) * PiHalfQ30) >> QuarterBits;
    sum  = x;
    term = x;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > OneQ30) begin
      sum = OneQ30;
    end
    mag = (64'(Amplitude) * sum) >> 30;
    if (mag > MagLimit) begin
      mag = MagLimit;
    end
    return mag[SampleW-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i < QuarterLen; i++) begin
      t[i] = quarter_mag(i);
    end
    return t;
  endfunction

  localparam qtab_t QTab = build_qtab();
  localparam logic [SampleW-1:0] QPeak = quarter_mag(QuarterLen);

  typedef struct packed {
    cmd_e                   cmd;
    logic [StepLoProdW-1:0] step_lo;
    logic [StepHiProdW-1:0] step_hi;
    logic [CountProdW-1:0]  count_prod;
  } stbg_pre_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } stbg_res_t;

  typedef struct packed {
    logic take;
    logic load;
    logic last;
    logic busy;
  } stbg_ctl_t;

endpackage

FILE: design/stbg_in_if.sv
// Input channel: command items with valid and ready.
interface stbg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [stbg_pkg::FreqW-1:0]  frequency_hz;
  logic [stbg_pkg::MsW-1:0]    duration_ms;

  modport source(output valid, output cmd, output frequency_hz, output duration_ms,
                 input ready);
  modport sink(input valid, input cmd, input frequency_hz, input duration_ms,
               output ready);
endinterface

FILE: design/stbg_out_if.sv
// Output channel: sine sample items with valid and ready.
interface stbg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [stbg_pkg::SampleW-1:0] sample;
  logic                                last;

  modport source(output valid, output sample, output last, input ready);
  modport sink(input valid, input sample, input last, output ready);
endinterface

FILE: design/stbg_in_stage.sv
// Input register with the step and count partial products formed on the way in.
module stbg_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  stbg_in_if.sink             in_i,
  input  logic                take_i,
  output logic                valid_o,
  output stbg_pkg::stbg_pre_t pre_o
);

  logic                valid_q;
  logic                valid_d;
  logic                accept;
  stbg_pkg::stbg_pre_t pre_q;
  stbg_pkg::stbg_pre_t pre_d;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign valid_d    = accept || (valid_q && !take_i);

  always_comb begin
    pre_d.cmd        = stbg_pkg::cmd_e'(in_i.cmd);
    pre_d.step_lo    = stbg_pkg::StepLoProdW'(in_i.frequency_hz)
                     * stbg_pkg::StepLoProdW'(stbg_pkg::StepMulLo);
    pre_d.step_hi    = stbg_pkg::StepHiProdW'(in_i.frequency_hz)
                     * stbg_pkg::StepHiProdW'(stbg_pkg::StepMulHi);
    pre_d.count_prod = stbg_pkg::CountProdW'(in_i.duration_ms)
                     * stbg_pkg::CountProdW'(stbg_pkg::CountMul);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pre_q <= pre_d;
    end
  end

  assign valid_o = valid_q;
  assign pre_o   = pre_q;

endmodule

FILE: design/stbg_core.sv
// Burst state, phase accumulator, sine lookup and the enable register.
module stbg_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                valid_i,
  input  stbg_pkg::stbg_pre_t pre_i,
  input  logic                slot_free_i,
  output stbg_pkg::stbg_ctl_t ctl_o,
  output stbg_pkg::stbg_res_t res_o
);

  logic                                enabled_q;
  logic [stbg_pkg::PhaseW-1:0]         acc_q;
  logic [stbg_pkg::PhaseW-1:0]         acc_d;
  logic [stbg_pkg::PhaseW-1:0]         step_q;
  logic [stbg_pkg::PhaseW-1:0]         step_d;
  logic [stbg_pkg::CountW-1:0]         left_q;
  logic [stbg_pkg::CountW-1:0]         left_d;

  logic                                busy;
  logic                                produce;
  logic                                take;
  logic [stbg_pkg::StepProdW-1:0]      step_full;
  logic [stbg_pkg::PhaseW-1:0]         new_step;
  logic [stbg_pkg::CountRawW-1:0]      count_raw;
  logic [stbg_pkg::CountW-1:0]         new_count;
  logic [stbg_pkg::TableBits-1:0]      idx;
  logic [1:0]                          quad;
  logic [stbg_pkg::QuarterBits-1:0]    q;
  logic [stbg_pkg::QuarterBits-1:0]    q_sel;
  logic                                peak;
  logic [stbg_pkg::SampleW-1:0]        mag;
  logic [stbg_pkg::SampleW-1:0]        sample_bits;

  assign busy    = left_q != '0;
  assign produce = valid_i && (pre_i.cmd == stbg_pkg::CmdTick) && busy;
  assign take    = valid_i && (!produce || slot_free_i);

  assign step_full = (stbg_pkg::StepProdW'(pre_i.step_hi) << stbg_pkg::StepLoW)
                   + stbg_pkg::StepProdW'(pre_i.step_lo);
  assign new_step  = step_full[stbg_pkg::StepShift+stbg_pkg::PhaseW-1:stbg_pkg::StepShift];

  assign count_raw = pre_i.count_prod[stbg_pkg::CountProdW-1:stbg_pkg::CountShift];
  assign new_count = (count_raw > stbg_pkg::CountRawW'(stbg_pkg::CountMax))
                   ? stbg_pkg::CountMax : count_raw[stbg_pkg::CountW-1:0];

  // Quarter-wave lookup: odd quadrants mirror the index, the second half negates.
  assign idx   = acc_q[stbg_pkg::PhaseW-1 -: stbg_pkg::TableBits];
  assign quad  = idx[stbg_pkg::TableBits-1 -: 2];
  assign q     = idx[stbg_pkg::QuarterBits-1:0];
  assign q_sel = quad[0] ? (stbg_pkg::QuarterBits'(0) - q) : q;
  assign peak  = quad[0] && (q == '0);
  assign mag   = peak ? stbg_pkg::QPeak : stbg_pkg::QTab[q_sel];

  always_comb begin
    if (quad[1]) begin
      sample_bits = stbg_pkg::SampleW'(0) - mag;
    end else if (mag > stbg_pkg::MaxPos) begin
      sample_bits = stbg_pkg::MaxPos;
    end else begin
      sample_bits = mag;
    end
  end

  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    left_d = left_q;
    if (take) begin
      unique case (pre_i.cmd)
        stbg_pkg::CmdStart: begin
          if (enabled_q) begin
            acc_d  = '0;
            step_d = new_step;
            left_d = new_count;
          end
        end
        stbg_pkg::CmdTick: begin
          if (busy) begin
            acc_d  = acc_q + step_q;
            left_d = left_q - stbg_pkg::CountW'(1);
          end
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      acc_q     <= '0;
      step_q    <= '0;
      left_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      acc_q  <= acc_d;
      step_q <= step_d;
      left_q <= left_d;
    end
  end

  assign ctl_o.take  = take;
  assign ctl_o.load  = take && produce;
  assign ctl_o.last  = left_q == stbg_pkg::CountW'(1);
  assign ctl_o.busy  = busy;
  assign res_o.sample = $signed(sample_bits);
  assign res_o.last   = ctl_o.last;

endmodule

FILE: design/stbg_out_reg.sv
// Result register that holds a sample item until the sink takes it.
module stbg_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  stbg_pkg::stbg_res_t res_i,
  stbg_out_if.source          out_o,
  output logic                slot_free_o
);

  logic                valid_q;
  logic                valid_d;
  stbg_pkg::stbg_res_t res_q;

  assign slot_free_o = !valid_q || out_o.ready;
  assign valid_d     = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid  = valid_q;
  assign out_o.sample = res_q.sample;
  assign out_o.last   = res_q.last;

endmodule

FILE: design/sine_tone_burst_generator.sv
// Top level of the sine tone-burst generator.
// A start item (cmd 0) arms a burst of 16 samples per millisecond of duration_ms at
// a phase step of frequency_hz * 2^32 / 16000 and resets the phase; it is dropped
// while the enable register is clear, and a start during a burst restarts it. Each
// tick item (cmd 1) during a burst yields one sample item, a 1024-point sine scaled
// to +/-12000, with last set on the final sample; ticks outside a burst yield
// nothing. One item is taken per clock cycle, but a tick is held while a finished
// sample waits in the output register and the sink does not take it. An item waits
// in the input register until the core takes it, and the sample of a tick is
// registered in the output register as the tick is taken. The rate is set by the
// phase accumulator and sample counter update; start items pass while a sample waits.
module sine_tone_burst_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  stbg_in_if.sink    in_i,
  stbg_out_if.source out_o
);

  logic                s1_valid;
  logic                slot_free;
  stbg_pkg::stbg_pre_t pre;
  stbg_pkg::stbg_ctl_t ctl;
  stbg_pkg::stbg_res_t res;

  stbg_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (ctl.take),
    .valid_o (s1_valid),
    .pre_o   (pre)
  );

  stbg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (s1_valid),
    .pre_i       (pre),
    .slot_free_i (slot_free),
    .ctl_o       (ctl),
    .res_o       (res)
  );

  stbg_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctl.load),
    .res_i       (res),
    .out_o       (out_o),
    .slot_free_o (slot_free)
  );

`ifndef SYNTH
  // A held item that the core cannot take must block the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !ctl.take) |-> !in_i.ready)
    else $error("input accepted while the input register is blocked");

  // A sample is loaded only into a free output slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load |-> (!out_o.valid || out_o.ready))
    else $error("sample loaded over an item still waiting");

  // The final sample of a burst leaves the generator idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.load && ctl.last) |=> !ctl.busy)
    else $error("burst still running after its final sample");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the sine tone-burst generator, with its own sample predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RateHz     = 16000;
  localparam int unsigned Amp        = 12000;
  localparam int unsigned QuadBits   = stbg_pkg::TableBits - 2;
  localparam int unsigned QuarterPts = 1 << QuadBits;
  localparam logic [63:0] PiHalf     = 64'd1686629713;
  localparam logic [63:0] UnitQ30    = 64'd1073741824;
  localparam logic [63:0] BurstMax   = 64'd1048575;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  stbg_in_if  in_if();
  stbg_out_if out_if();

  sine_tone_burst_generator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  logic                        tone_en;
  logic [stbg_pkg::PhaseW-1:0] tone_phase;
  logic [stbg_pkg::PhaseW-1:0] tone_step;
  logic [stbg_pkg::CountW-1:0] tone_left;
  stbg_pkg::stbg_res_t         samples_due[$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned samples_seen;
  int unsigned bursts_ended;
  int unsigned cycles;
  bit          tx_gaps;
  bit          rx_idle;
  int unsigned rx_hold;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d samples still due", $time, samples_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sine magnitude in Q2.30 over the first quadrant, from an order-17 Taylor series.
  function automatic logic [63:0] quadrant_sine(logic [63:0] q);
    logic [63:0] x;
    logic [63:0] acc;
    logic [63:0] t;
    x   = (q * PiHalf) >> QuadBits;
    acc = x;
    t   = x;
    for (int n = 1; n <= 8; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        acc = acc - t;
      end else begin
        acc = acc + t;
      end
    end
    if (acc > UnitQ30) begin
      acc = UnitQ30;
    end
    return acc;
  endfunction

  function automatic logic [stbg_pkg::SampleW-1:0] sine_lookup(
      logic [stbg_pkg::TableBits-1:0] idx);
    logic [1:0]  quad;
    logic [63:0] q;
    logic [63:0] mag;
    quad = idx[stbg_pkg::TableBits-1 -: 2];
    q    = 64'(idx[QuadBits-1:0]);
    if (quad[0]) begin
      mag = quadrant_sine(64'(QuarterPts) - q);
    end else begin
      mag = quadrant_sine(q);
    end
    mag = (64'(Amp) * mag) >> 30;
    if (quad[1]) begin
      if (mag > 64'd16384) begin
        mag = 64'd16384;
      end
      mag = -mag;
    end else if (mag > 64'd16383) begin
      mag = 64'd16383;
    end
    return mag[stbg_pkg::SampleW-1:0];
  endfunction

  // Predicts on every accepted item and checks every accepted sample, in one process.
  always @(posedge clk_i) begin : tone_monitor
    logic [63:0]         wide;
    stbg_pkg::stbg_res_t due;
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (in_if.cmd == stbg_pkg::CmdStart) begin
        if (tone_en) begin
          wide = (64'(RateHz) * 64'(in_if.duration_ms)) / 64'd1000;
          if (wide > BurstMax) begin
            wide = BurstMax;
          end
          tone_left  = wide[stbg_pkg::CountW-1:0];
          wide       = (64'(in_if.frequency_hz) << 32) / 64'(RateHz);
          tone_step  = wide[stbg_pkg::PhaseW-1:0];
          tone_phase = '0;
        end
      end else if (tone_left != 0) begin
        due.sample = sine_lookup(tone_phase[stbg_pkg::PhaseW-1 -: stbg_pkg::TableBits]);
        due.last   = (tone_left == 1);
        samples_due.push_back(due);
        tone_phase = tone_phase + tone_step;
        tone_left  = tone_left - 1'b1;
      end
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      samples_seen++;
      if (samples_due.size() == 0) begin
        errors++;
        $display("%0t: expected no sample, got sample %0d last %0b", $time,
                 out_if.sample, out_if.last);
      end else begin
        due = samples_due.pop_front();
        if (out_if.sample !== due.sample) begin
          errors++;
          $display("%0t: sample expected %0d got %0d", $time, due.sample, out_if.sample);
        end
        if (out_if.last !== due.last) begin
          errors++;
          $display("%0t: last expected %0b got %0b", $time, due.last, out_if.last);
        end
        if (due.last) begin
          bursts_ended++;
        end
      end
    end
  end

  // Output ready: random stalls, plus a long hold-off when one is requested.
  initial begin : sample_sink
    int unsigned rx_left;
    out_if.ready = 1'b0;
    rx_left      = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold != 0) begin
        rx_left = rx_hold;
        rx_hold = 0;
      end else if (rx_left == 0 && rx_idle && $urandom_range(0, 7) == 0) begin
        rx_left = $urandom_range(1, 19);
      end
      if (rx_left != 0) begin
        out_if.ready <= 1'b0;
        rx_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(stbg_pkg::cmd_e c, logic [stbg_pkg::FreqW-1:0] f,
                           logic [stbg_pkg::MsW-1:0] d);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= c;
    in_if.frequency_hz <= f;
    in_if.duration_ms  <= d;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(stbg_pkg::CmdTick, stbg_pkg::FreqW'($urandom),
                         stbg_pkg::MsW'($urandom));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_enable(logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tone_en  = v;
  endtask

  task automatic test_idle_and_disabled();
    send_ticks(2);
    send_item(stbg_pkg::CmdStart, 16'd1000, 16'd1);
    send_ticks(2);
    drain();
  endtask

  task automatic test_extremes();
    send_item(stbg_pkg::CmdStart, 16'd0, 16'd0);
    send_ticks(1);
    send_item(stbg_pkg::CmdStart, 16'hFFFF, 16'hFFFF);
    send_ticks(3);
    send_item(stbg_pkg::CmdStart, 16'd16000, 16'd1);
    send_ticks(2);
    send_item(stbg_pkg::CmdStart, 16'd4000, 16'd1);
    send_ticks(5);
    drain();
  endtask

  task automatic test_disable_midburst();
    send_item(stbg_pkg::CmdStart, 16'd1234, 16'd1);
    send_ticks(6);
    drain();
    write_enable(1'b0);
    send_item(stbg_pkg::CmdStart, 16'd500, 16'd2);
    send_ticks(11);
    drain();
    write_enable(1'b1);
  endtask

  task automatic test_backpressure();
    bit saved_gaps;
    saved_gaps = tx_gaps;
    tx_gaps    = 1'b0;
    send_item(stbg_pkg::CmdStart, stbg_pkg::FreqW'($urandom), 16'd4);
    rx_hold = 120;
    send_ticks(40);
    tx_gaps = saved_gaps;
    drain();
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned                start_count;
    int unsigned                n_ticks;
    logic [stbg_pkg::FreqW-1:0] f;
    logic [stbg_pkg::MsW-1:0]   d;
    bit                         long_burst;
    start_count = items_sent;
    while (items_sent - start_count < n_items) begin
      case ($urandom_range(0, 3))
        0: f = stbg_pkg::FreqW'($urandom_range(0, 65535));
        1: f = stbg_pkg::FreqW'($urandom_range(16000, 65535));
        default: f = stbg_pkg::FreqW'($urandom_range(1, 4000));
      endcase
      long_burst = ($urandom_range(0, 9) == 0);
      if (long_burst) begin
        d       = stbg_pkg::MsW'($urandom_range(0, 65535));
        n_ticks = $urandom_range(0, 6);
      end else begin
        d = stbg_pkg::MsW'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
          n_ticks = $urandom_range(0, 16 * d);
        end else begin
          n_ticks = 16 * d + $urandom_range(0, 3);
        end
      end
      send_item(stbg_pkg::CmdStart, f, d);
      send_ticks(n_ticks);
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 1'b0;
    in_if.valid        = 1'b0;
    in_if.cmd          = stbg_pkg::CmdStart;
    in_if.frequency_hz = '0;
    in_if.duration_ms  = '0;
    tone_en            = 1'b0;
    tone_phase         = '0;
    tone_step          = '0;
    tone_left          = '0;
    errors             = 0;
    items_sent         = 0;
    samples_seen       = 0;
    bursts_ended       = 0;
    cycles             = 0;
    tx_gaps            = 1'b0;
    rx_idle            = 1'b0;
    rx_hold            = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_and_disabled();
    write_enable(1'b1);
    test_extremes();
    rx_idle = 1'b1;
    tx_gaps = 1'b1;
    test_disable_midburst();
    test_backpressure();
    test_random(200);
    drain();
    write_enable(1'b1);
    test_random(200);
    drain();
    tx_gaps = 1'b0;
    rx_idle = 1'b0;
    test_random(100);
    drain();

    $display("Sent %0d items and checked %0d samples, %0d of them ending a burst.",
             items_sent, samples_seen, bursts_ended);
    $display("Covered idle ticks, disabled and restarted bursts, zero and maximum %s",
             "durations, aliased frequencies and a long output stall.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
